@@ rtl/efr_pkg.sv @@
// Shared widths and types for the edge-function triangle rasterizer.
// No dependencies; imported by efr_setup, efr_walk and the top level.
`default_nettype none
package efr_pkg;

  localparam int CW  = 11;          // coordinate bits
  localparam int AW  = CW + 1;      // edge slope bits
  localparam int SW  = CW + 2;      // sum of three coordinates
  localparam int CCW = 2 * CW + 1;  // edge offset bits
  localparam int PW  = 2 * CW;      // coordinate product bits
  localparam int EW  = 2 * CW + 3;  // edge value bits
  localparam int TW  = 2 * CW + 4;  // centroid test bits

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [AW-1:0]  slope_t;
  typedef logic signed [CCW-1:0] offset_t;
  typedef logic signed [EW-1:0]  eval_t;

  typedef struct packed {
    coord_t x_lo;
    coord_t x_hi;
    coord_t y_lo;
    coord_t y_hi;
  } box_t;

  typedef struct packed {
    slope_t [2:0] slope_x;
    slope_t [2:0] slope_y;
    eval_t  [2:0] start_val;
    box_t         box;
  } edge_setup_t;

endpackage
`default_nettype wire

@@ rtl/efr_setup.sv @@
// Triangle setup pipeline: edge coefficients, orientation, box, start values.
// Three registered stages; depends on efr_pkg.
`default_nettype none
module efr_setup (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  efr_pkg::coord_t      vax,
  input  efr_pkg::coord_t      vay,
  input  efr_pkg::coord_t      vbx,
  input  efr_pkg::coord_t      vby,
  input  efr_pkg::coord_t      vcx,
  input  efr_pkg::coord_t      vcy,
  output logic                 busy,
  output logic                 done,
  output efr_pkg::edge_setup_t setup
);
  import efr_pkg::*;

  // stage 0: vertices
  coord_t vx_r [3];
  coord_t vy_r [3];
  logic   s0_vld_r;

  // stage 1: raw edges
  slope_t  a1_r [3];
  slope_t  b1_r [3];
  offset_t c1_r [3];
  logic signed [SW-1:0] sumx_r, sumy_r;
  box_t    box1_r;
  logic    s1_vld_r;

  // stage 2: oriented edges
  slope_t  a2_r [3];
  slope_t  b2_r [3];
  offset_t c2_r [3];
  box_t    box2_r;
  logic    s2_vld_r;

  edge_setup_t setup_r;
  logic        done_r;

  // stage 0 logic
  coord_t  x1 [3], y1 [3], x2 [3], y2 [3];
  slope_t  a1_nxt [3], b1_nxt [3];
  offset_t c1_nxt [3];
  logic signed [PW-1:0] p1 [3], p2 [3];
  box_t    box1_nxt;

  always_comb begin
    x1[0] = vx_r[0]; y1[0] = vy_r[0]; x2[0] = vx_r[1]; y2[0] = vy_r[1];
    x1[1] = vx_r[1]; y1[1] = vy_r[1]; x2[1] = vx_r[2]; y2[1] = vy_r[2];
    x1[2] = vx_r[0]; y1[2] = vy_r[0]; x2[2] = vx_r[2]; y2[2] = vy_r[2];
    for (int k = 0; k < 3; k++) begin
      a1_nxt[k] = AW'(y2[k]) - AW'(y1[k]);
      b1_nxt[k] = AW'(x1[k]) - AW'(x2[k]);
      p1[k]     = PW'(x2[k]) * PW'(y1[k]);
      p2[k]     = PW'(x1[k]) * PW'(y2[k]);
      c1_nxt[k] = CCW'(p1[k]) - CCW'(p2[k]);
    end
    box1_nxt.x_lo = vx_r[0];
    box1_nxt.x_hi = vx_r[0];
    box1_nxt.y_lo = vy_r[0];
    box1_nxt.y_hi = vy_r[0];
    for (int k = 1; k < 3; k++) begin
      if (vx_r[k] < box1_nxt.x_lo) box1_nxt.x_lo = vx_r[k];
      if (vx_r[k] > box1_nxt.x_hi) box1_nxt.x_hi = vx_r[k];
      if (vy_r[k] < box1_nxt.y_lo) box1_nxt.y_lo = vy_r[k];
      if (vy_r[k] > box1_nxt.y_hi) box1_nxt.y_hi = vy_r[k];
    end
  end

  // stage 1 logic: centroid test, sums scaled by three
  logic signed [EW-1:0] pa [3], pb [3];
  logic signed [TW-1:0] test [3];
  slope_t  a2_nxt [3], b2_nxt [3];
  offset_t c2_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa[k]   = EW'(a1_r[k]) * EW'(sumx_r);
      pb[k]   = EW'(b1_r[k]) * EW'(sumy_r);
      test[k] = TW'(pa[k]) + TW'(pb[k]) + TW'(c1_r[k]) + (TW'(c1_r[k]) <<< 1);
      if (test[k] < 0) begin
        a2_nxt[k] = -a1_r[k];
        b2_nxt[k] = -b1_r[k];
        c2_nxt[k] = -c1_r[k];
      end else begin
        a2_nxt[k] = a1_r[k];
        b2_nxt[k] = b1_r[k];
        c2_nxt[k] = c1_r[k];
      end
    end
  end

  // stage 2 logic: edge values at the box origin
  logic signed [CCW-1:0] qa [3], qb [3];
  edge_setup_t setup_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qa[k] = CCW'(a2_r[k]) * CCW'(box2_r.x_lo);
      qb[k] = CCW'(b2_r[k]) * CCW'(box2_r.y_lo);
      setup_nxt.start_val[k] = EW'(qa[k]) + EW'(qb[k]) + EW'(c2_r[k]);
      setup_nxt.slope_x[k]   = a2_r[k];
      setup_nxt.slope_y[k]   = b2_r[k];
    end
    setup_nxt.box = box2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s0_vld_r <= start;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      done_r   <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vx_r[0] <= vax; vy_r[0] <= vay;
      vx_r[1] <= vbx; vy_r[1] <= vby;
      vx_r[2] <= vcx; vy_r[2] <= vcy;
    end
    if (s0_vld_r) begin
      for (int k = 0; k < 3; k++) begin
        a1_r[k] <= a1_nxt[k];
        b1_r[k] <= b1_nxt[k];
        c1_r[k] <= c1_nxt[k];
      end
      sumx_r <= SW'(vx_r[0]) + SW'(vx_r[1]) + SW'(vx_r[2]);
      sumy_r <= SW'(vy_r[0]) + SW'(vy_r[1]) + SW'(vy_r[2]);
      box1_r <= box1_nxt;
    end
    if (s1_vld_r) begin
      for (int k = 0; k < 3; k++) begin
        a2_r[k] <= a2_nxt[k];
        b2_r[k] <= b2_nxt[k];
        c2_r[k] <= c2_nxt[k];
      end
      box2_r <= box1_r;
    end
    if (s2_vld_r) begin
      setup_r <= setup_nxt;
    end
  end

  assign busy  = s0_vld_r | s1_vld_r | s2_vld_r | done_r;
  assign done  = done_r;
  assign setup = setup_r;

endmodule
`default_nettype wire

@@ rtl/efr_walk.sv @@
// Bounding-box walk: incremental edge values, coverage test, result register.
// Loaded from efr_setup; depends on efr_pkg.
`default_nettype none
module efr_walk (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  load,
  input  efr_pkg::edge_setup_t setup,
  input  wire                  abort,
  input  wire                  step,
  input  wire                  out_stall,
  output logic                 out_valid,
  output efr_pkg::coord_t      pixel_x,
  output efr_pkg::coord_t      pixel_y,
  output logic                 covered,
  output logic                 last_candidate
);
  import efr_pkg::*;

  logic        active_r;
  slope_t      sx_r [3];
  slope_t      sy_r [3];
  eval_t       cur_r [3];
  eval_t       col_r [3];
  box_t        box_r;
  coord_t      scan_x_r, scan_y_r;

  logic        out_valid_r;
  coord_t      pixel_x_r, pixel_y_r;
  logic        covered_r, last_r;

  logic emit, cov, last, y_more;
  eval_t col_nxt [3];

  assign emit   = step & active_r;
  assign last   = (scan_x_r >= box_r.x_hi) && (scan_y_r >= box_r.y_hi);
  assign y_more = scan_y_r < box_r.y_hi;

  always_comb begin
    cov = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (cur_r[k] <= 0) cov = 1'b0;
      col_nxt[k] = col_r[k] + EW'(sx_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        active_r <= 1'b1;
      end else if (abort || (emit && last)) begin
        active_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 3; k++) begin
        sx_r[k]  <= setup.slope_x[k];
        sy_r[k]  <= setup.slope_y[k];
        cur_r[k] <= setup.start_val[k];
        col_r[k] <= setup.start_val[k];
      end
      box_r    <= setup.box;
      scan_x_r <= setup.box.x_lo;
      scan_y_r <= setup.box.y_lo;
    end else if (emit && !last) begin
      if (y_more) begin
        scan_y_r <= scan_y_r + CW'(1);
        for (int k = 0; k < 3; k++) begin
          cur_r[k] <= cur_r[k] + EW'(sy_r[k]);
        end
      end else begin
        scan_y_r <= box_r.y_lo;
        scan_x_r <= scan_x_r + CW'(1);
        for (int k = 0; k < 3; k++) begin
          col_r[k] <= col_nxt[k];
          cur_r[k] <= col_nxt[k];
        end
      end
    end
    if (emit) begin
      pixel_x_r <= scan_x_r;
      pixel_y_r <= scan_y_r;
      covered_r <= cov;
      last_r    <= last;
    end
  end

  assign out_valid      = out_valid_r;
  assign pixel_x        = pixel_x_r;
  assign pixel_y        = pixel_y_r;
  assign covered        = covered_r;
  assign last_candidate = last_r;

endmodule
`default_nettype wire

@@ rtl/edge_function_triangle_rasterizer.sv @@
// Top level of the edge-function triangle rasterizer: handshake and glue.
// Instantiates efr_setup and efr_walk; depends on efr_pkg.
//
//   channel | direction | beat
//   in_     | input     | action + three vertices (start) or step request
//   out_    | output    | pixel_x, pixel_y, covered, last_candidate
//
// A step beat yields its result in the next cycle while a walk is active; steps run
// one per cycle while in_stall is low. A start beat holds in_stall high while
// the three setup stages and the walk load complete.
// out_stall backs up into in_stall through the single result register.
// Reset clears control only; the block comes up idle.
`default_nettype none
module edge_function_triangle_rasterizer (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire              in_action,
  input  efr_pkg::coord_t  in_vertex_a_x,
  input  efr_pkg::coord_t  in_vertex_a_y,
  input  efr_pkg::coord_t  in_vertex_b_x,
  input  efr_pkg::coord_t  in_vertex_b_y,
  input  efr_pkg::coord_t  in_vertex_c_x,
  input  efr_pkg::coord_t  in_vertex_c_y,
  output logic             out_valid,
  input  wire              out_stall,
  output efr_pkg::coord_t  out_pixel_x,
  output efr_pkg::coord_t  out_pixel_y,
  output logic             out_covered,
  output logic             out_last_candidate
);
  import efr_pkg::*;

  logic        busy, done, in_acc, start, step;
  edge_setup_t setup;

  assign in_stall = busy | (out_valid & out_stall);
  assign in_acc   = in_valid & ~in_stall;
  assign start    = in_acc & ~in_action;
  assign step     = in_acc & in_action;

  efr_setup u_setup (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .vax   (in_vertex_a_x),
    .vay   (in_vertex_a_y),
    .vbx   (in_vertex_b_x),
    .vby   (in_vertex_b_y),
    .vcx   (in_vertex_c_x),
    .vcy   (in_vertex_c_y),
    .busy  (busy),
    .done  (done),
    .setup (setup)
  );

  efr_walk u_walk (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (done),
    .setup          (setup),
    .abort          (start),
    .step           (step),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .pixel_x        (out_pixel_x),
    .pixel_y        (out_pixel_y),
    .covered        (out_covered),
    .last_candidate (out_last_candidate)
  );

endmodule
`default_nettype wire
